// ----- src/lruc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared constants, controller state type and the command and status
// structs that join the controller to the datapath of the LRU cache.
// ----------------------------------------------------------------------------
package lruc_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAX_WAYS  = 32;
  localparam int DEF_KEY_BYTES = 8;

  // Fixed field widths.
  localparam int KEY_W   = 64;
  localparam int CFG_W   = 6;
  localparam int COST_W  = 3;
  localparam int SUM_W   = 32;
  localparam int OUT_W   = 1 + COST_W + SUM_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Access costs and the distance between lower and upper case in ASCII.
  localparam logic [COST_W-1:0] HIT_COST   = 3'd1;
  localparam logic [COST_W-1:0] MISS_COST  = 3'd5;
  localparam logic [7:0]        CASE_SHIFT = 8'd32;
  localparam logic [7:0]        CHAR_LO_A  = 8'h61;
  localparam logic [7:0]        CHAR_LO_Z  = 8'h7A;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture the input key and clear the lookup flags
    logic scan_rd;  // read the entry at the scan counter and advance
    logic commit;   // apply the update and load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic skip_scan;  // nothing to look through: capacity or fill is zero
    logic scan_last;  // the scan counter points at the last held entry
    logic out_free;   // the result register can take a new result
  } status_t;

endpackage

// ----- src/lruc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lruc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/lruc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_dp
// Datapath of the LRU cache: key folding, key store, rank registers, scan
// counter with match and victim search, cost total and result register.
// ----------------------------------------------------------------------------
module lruc_dp #(
  parameter int MAX_WAYS  = lruc_pkg::DEF_MAX_WAYS,
  parameter int KEY_BYTES = lruc_pkg::DEF_KEY_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lruc_pkg::cmd_t                    cmd,
  output lruc_pkg::status_t                 status,
  input  logic [lruc_pkg::KEY_W-1:0]        in_key,
  input  logic                              cfg_wr_en,
  input  logic [lruc_pkg::CFG_W-1:0]        cfg_wr_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lruc_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int IDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int RANK_W = IDX_W;
  localparam int CMP_W  = (CNT_W > lruc_pkg::CFG_W) ? CNT_W : lruc_pkg::CFG_W;
  localparam int KW     = lruc_pkg::KEY_W;
  localparam int SW     = lruc_pkg::SUM_W;
  localparam int CW     = lruc_pkg::COST_W;

  logic [lruc_pkg::CFG_W-1:0] capacity_r;
  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  held_r;
  logic [KW-1:0]     key_fold;
  logic [KW-1:0]     key_r;
  logic [IDX_W-1:0]  cnt_r;
  logic              cmp_vld_r;
  logic [RANK_W-1:0] cmp_rank_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [KW-1:0]     ram_rd_data;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [RANK_W-1:0] hit_rank_r;
  logic [IDX_W-1:0]  vic_idx_r;
  logic [RANK_W-1:0] rank_r [MAX_WAYS];
  logic              do_upd;
  logic              fill;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  touch_idx;
  logic [CW-1:0]     cost;
  logic [SW:0]       sum_ext;
  logic [SW-1:0]     sum_r;
  logic [SW-1:0]     sum_nxt;
  logic              out_vld_r;
  logic              out_hit_r;
  logic [CW-1:0]     out_cost_r;
  logic [SW-1:0]     out_sum_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  // Capacity limited to the number of ways built.
  always_comb begin
    if (CMP_W'(capacity_r) > CMP_W'(MAX_WAYS)) begin
      cap_eff = CNT_W'(MAX_WAYS);
    end else begin
      cap_eff = CNT_W'(CMP_W'(capacity_r));
    end
  end

  // Fold lower-case letters to upper case; bytes beyond the key length are dropped.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      if (b >= KEY_BYTES) begin
        key_fold[8*b +: 8] = 8'h00;
      end else if (in_key[8*b +: 8] >= lruc_pkg::CHAR_LO_A &&
                   in_key[8*b +: 8] <= lruc_pkg::CHAR_LO_Z) begin
        key_fold[8*b +: 8] = in_key[8*b +: 8] - lruc_pkg::CASE_SHIFT;
      end else begin
        key_fold[8*b +: 8] = in_key[8*b +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key_fold;
    end
  end

  // Scan counter and the read stage alongside the key store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_rd;
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.scan_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      cmp_rank_r <= rank_r[cnt_r];
      cmp_idx_r  <= cnt_r;
    end
  end

  // Compare stage: first matching key, and the entry of the oldest rank.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r <= 1'b0;
    end else if (cmp_vld_r && !hit_r && ram_rd_data == key_r) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r && !hit_r && ram_rd_data == key_r) begin
      hit_idx_r  <= cmp_idx_r;
      hit_rank_r <= cmp_rank_r;
    end
    if (cmp_vld_r && CNT_W'(cmp_rank_r) == held_r - CNT_W'(1)) begin
      vic_idx_r <= cmp_idx_r;
    end
  end

  // Update decisions taken at commit.
  always_comb begin
    do_upd    = cmd.commit && (cap_eff != '0);
    fill      = !hit_r && (held_r < cap_eff);
    wr_idx    = fill ? IDX_W'(held_r) : vic_idx_r;
    touch_idx = hit_r ? hit_idx_r : wr_idx;
  end

  lruc_ram #(
    .WIDTH (KW),
    .DEPTH (MAX_WAYS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (do_upd && !hit_r),
    .wr_addr (wr_idx),
    .wr_data (key_r),
    .rd_en   (cmd.scan_rd),
    .rd_addr (cnt_r),
    .rd_data (ram_rd_data)
  );

  // Rank registers: the touched entry becomes most recent, younger ones age.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        rank_r[i] <= '0;
      end
    end else if (do_upd) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (IDX_W'(i) == touch_idx) begin
          rank_r[i] <= '0;
        end else if (CNT_W'(i) < held_r && (!hit_r || rank_r[i] < hit_rank_r)) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (do_upd && fill) begin
      held_r <= held_r + 1'b1;
    end
  end

  // Saturating cost total.
  always_comb begin
    cost    = hit_r ? lruc_pkg::HIT_COST : lruc_pkg::MISS_COST;
    sum_ext = {1'b0, sum_r} + (SW + 1)'(cost);
    sum_nxt = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.commit) begin
      sum_r <= sum_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.commit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r  <= hit_r;
      out_cost_r <= cost;
      out_sum_r  <= sum_nxt;
    end
  end

  // Status and outputs.
  always_comb begin
    status.skip_scan = (cap_eff == '0) || (held_r == '0);
    status.scan_last = (CNT_W'(cnt_r) == held_r - CNT_W'(1));
    status.out_free  = !out_vld_r || out_tready;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = lruc_pkg::OUT_TDATA_W'({out_sum_r, out_cost_r, out_hit_r});

endmodule

// ----- src/lruc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_ctrl
// Controller of the LRU cache: accepts a transaction, steps the scan over
// the held entries, and commits once the result register is free.
// ----------------------------------------------------------------------------
module lruc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lruc_pkg::status_t status,
  output lruc_pkg::cmd_t    cmd
);

  lruc_pkg::state_t state_r;
  lruc_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lruc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lruc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = status.skip_scan ? lruc_pkg::ST_COMMIT : lruc_pkg::ST_SCAN;
        end
      end
      lruc_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = lruc_pkg::ST_DRAIN;
        end
      end
      lruc_pkg::ST_DRAIN: begin
        state_nxt = lruc_pkg::ST_COMMIT;
      end
      lruc_pkg::ST_COMMIT: begin
        if (status.out_free) begin
          state_nxt = lruc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lruc_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    in_tready   = 1'b0;
    cmd.load    = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      lruc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      lruc_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      lruc_pkg::ST_DRAIN: begin
        cmd.scan_rd = 1'b0;
      end
      lruc_pkg::ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/lru_cache_access_cost.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_access_cost
// Fully associative LRU cache of eight-byte keys with per-access cost and a
// saturating running total.
//
//   Channel   Direction  Payload (lowest bit first)
//   in_       slave      tdata: key[63:0]
//   out_      master     tdata: hit[0], cost[3:1], total_cost[35:4], zero[39:36]
//   cfg_      write      wr_data: capacity[5:0]
//
// An accepted transaction scans each held entry in turn through the single
// RAM read port, passes a drain state that empties the read stage, and then
// commits to the output register; the scan and drain are skipped when the
// cache is empty or the capacity is zero. The controller returns to idle
// with the commit, so the next key is only accepted once the previous one
// has committed. Reset is synchronous and active low; the key store needs
// no clearing pass. A stalled output holds the commit until the result
// register frees up.
// ----------------------------------------------------------------------------
module lru_cache_access_cost #(
  parameter int MAX_WAYS  = lruc_pkg::DEF_MAX_WAYS,
  parameter int KEY_BYTES = lruc_pkg::DEF_KEY_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lruc_pkg::KEY_W-1:0]       in_tdata,   // key
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lruc_pkg::OUT_TDATA_W-1:0] out_tdata,  // hit, cost, total_cost
  input  logic                             cfg_wr_en,
  input  logic [lruc_pkg::CFG_W-1:0]       cfg_wr_data // capacity
);

  lruc_pkg::cmd_t    cmd;
  lruc_pkg::status_t status;

  // Controller.
  lruc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  lruc_dp #(
    .MAX_WAYS  (MAX_WAYS),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_key      (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
